>>> sv/w6e_pkg.sv
// Package for the 3-to-4 word expansion encoder.
// Holds lane masks, the group phase type and the result and state structs.
`default_nettype none

package w6e_pkg;

	localparam int unsigned WORD_W  = 32;
	localparam int unsigned PADDR_W = 3;

	localparam logic [PADDR_W-3:0] REG_CODE_OFFSET = 1'b0;

	localparam logic [WORD_W-1:0] KEEP0  = 32'h3F3F3F3F;
	localparam logic [WORD_W-1:0] EVICT0 = 32'hC0C0C0C0;
	localparam logic [WORD_W-1:0] FRONT1 = 32'hC0C0C0C0;
	localparam logic [WORD_W-1:0] KEEP1  = 32'h0F0F0F0F;
	localparam logic [WORD_W-1:0] EVICT1 = 32'h30303030;
	localparam logic [WORD_W-1:0] FRONT2 = 32'hF0F0F0F0;
	localparam logic [WORD_W-1:0] KEEP2  = 32'h03030303;
	localparam logic [WORD_W-1:0] EVICT2 = 32'h0C0C0C0C;

	typedef enum logic [1:0] {
		PH_0 = 2'd0,
		PH_1 = 2'd1,
		PH_2 = 2'd2
	} phase_t;

	typedef struct packed {
		phase_t              phase;
		logic [WORD_W-1:0]   gathered;
	} enc_state_t;

	typedef struct packed {
		logic [WORD_W-1:0] code;
		logic              last;
	} result_t;

endpackage

`default_nettype wire

>>> sv/w6e_in_if.sv
// Input channel of the encoder: one source word per handshake.
// Standalone interface with valid/ready and the source word payload.
`default_nettype none

interface w6e_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] data_word;
	logic        last_word;

	modport source (output valid, output data_word, output last_word, input ready);
	modport sink (input valid, input data_word, input last_word, output ready);
endinterface

`default_nettype wire

>>> sv/w6e_out_if.sv
// Output channel of the encoder: one code word per handshake.
// Standalone interface with valid/ready and the code word payload.
`default_nettype none

interface w6e_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] code_word;
	logic        last_code;

	modport source (output valid, output code_word, output last_code, input ready);
	modport sink (input valid, input code_word, input last_code, output ready);
endinterface

`default_nettype wire

>>> sv/word_6bit_expand_encoder.sv
// Top level of the 3-to-4 word expansion encoder with its APB register port.
// Depends on w6e_pkg, w6e_in_if, w6e_out_if and w6e_core.
// A source word is accepted in any cycle in which the two-entry result buffer can take both
// results it may cause; each result is registered in the buffer before it leaves. Every third word of a
// group, and the last word of a message, also yields the gathered word, so the single output
// channel sets the sustained rate at four code words per three source words. Register
// code_offset sits at byte address 0 and should be written only while the block is idle.
`default_nettype none

module word_6bit_expand_encoder
	import w6e_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	w6e_in_if.sink             data_in,
	w6e_out_if.source          code_out,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [WORD_W-1:0]  pwdata,
	output logic [WORD_W-1:0]  prdata,
	output logic               pready
);

	logic [WORD_W-1:0] code_offset_q;
	enc_state_t        state_q;
	enc_state_t        state_next;
	result_t           first;
	result_t           second;
	logic              two;
	logic              o_valid_q;
	result_t           o_q;
	logic              p_valid_q;
	result_t           p_q;
	logic              accept;
	logic              o_fire;
	logic              reg_hit;

	assign pready  = 1'b1;
	assign reg_hit = (paddr[PADDR_W-1:2] == REG_CODE_OFFSET);
	assign prdata  = reg_hit ? code_offset_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_offset_q <= '0;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			code_offset_q <= pwdata;
		end
	end

	w6e_core u_core (
		.state      (state_q),
		.offset     (code_offset_q),
		.data_word  (data_in.data_word),
		.last_word  (data_in.last_word),
		.first      (first),
		.second     (second),
		.two        (two),
		.state_next (state_next)
	);

	assign o_fire        = o_valid_q && code_out.ready;
	assign data_in.ready = !p_valid_q && (!o_valid_q || code_out.ready);
	assign accept        = data_in.valid && data_in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= '{phase: PH_0, gathered: '0};
			o_valid_q <= 1'b0;
			p_valid_q <= 1'b0;
		end else if (accept) begin
			state_q   <= state_next;
			o_valid_q <= 1'b1;
			p_valid_q <= two;
		end else if (o_fire) begin
			o_valid_q <= p_valid_q;
			p_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			o_q <= first;
			p_q <= second;
		end else if (o_fire) begin
			o_q <= p_q;
		end
	end

	assign code_out.valid     = o_valid_q;
	assign code_out.code_word = o_q.code;
	assign code_out.last_code = o_q.last;

endmodule

`default_nettype wire

>>> sv/w6e_core.sv
// Combinational encode step: one source word against the group state.
// Depends on w6e_pkg for masks, phase type and result structs.
`default_nettype none

module w6e_core
	import w6e_pkg::*;
(
	input  enc_state_t        state,
	input  logic [WORD_W-1:0] offset,
	input  logic [WORD_W-1:0] data_word,
	input  logic              last_word,
	output result_t           first,
	output result_t           second,
	output logic              two,
	output enc_state_t        state_next
);

	logic [WORD_W-1:0] code;
	logic [WORD_W-1:0] gath;
	phase_t            phase_adv;
	logic              flush;

	always_comb begin
		case (state.phase)
			PH_0:    phase_adv = PH_1;
			PH_1:    phase_adv = PH_2;
			PH_2:    phase_adv = PH_0;
			default: phase_adv = PH_1;
		endcase
	end

	always_comb begin
		case (state.phase)
			PH_1: begin
				code = ((data_word & FRONT1) >> 2) | (data_word & KEEP1);
				gath = state.gathered | (data_word & EVICT1);
			end
			PH_2: begin
				code = ((data_word & FRONT2) >> 2) | (data_word & KEEP2);
				gath = state.gathered | (data_word & EVICT2);
			end
			default: begin
				code = data_word & KEEP0;
				gath = data_word & EVICT0;
			end
		endcase
	end

	assign flush = last_word || (state.phase == PH_2);

	assign first.code  = code + offset;
	assign first.last  = 1'b0;
	assign second.code = (gath >> 2) + offset;
	assign second.last = last_word;
	assign two         = flush;

	assign state_next.phase    = flush ? PH_0 : phase_adv;
	assign state_next.gathered = flush ? '0 : gath;

endmodule

`default_nettype wire

>>> sv/w6e_checker.sv
// Port-level checks for the encoder, attached to the top level by a bind.
// Depends on w6e_pkg for the word and address widths and the register offset.
`default_nettype none

module w6e_checker
	import w6e_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               in_last,
	input logic               out_valid,
	input logic               out_ready,
	input logic [WORD_W-1:0]  out_code,
	input logic               out_last,
	input logic               psel,
	input logic               penable,
	input logic               pwrite,
	input logic [PADDR_W-1:0] paddr,
	input logic [WORD_W-1:0]  pwdata,
	input logic [WORD_W-1:0]  prdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_code) && $stable(out_last))
		else $error("stalled code word changed or dropped");

	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled while no code word is pending");

	a_last_emits: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_last |=> out_valid && !in_ready)
		else $error("last word did not leave both results pending");

	a_cfg_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && paddr[PADDR_W-1:2] == REG_CODE_OFFSET
		|=> paddr[PADDR_W-1:2] != REG_CODE_OFFSET || prdata == $past(pwdata))
		else $error("code_offset readback does not match the written value");

endmodule

bind word_6bit_expand_encoder w6e_checker u_w6e_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (data_in.valid),
	.in_ready  (data_in.ready),
	.in_last   (data_in.last_word),
	.out_valid (code_out.valid),
	.out_ready (code_out.ready),
	.out_code  (code_out.code_word),
	.out_last  (code_out.last_code),
	.psel      (psel),
	.penable   (penable),
	.pwrite    (pwrite),
	.paddr     (paddr),
	.pwdata    (pwdata),
	.prdata    (prdata)
);

`default_nettype wire
